@@ sv/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants and types for the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int SST_CAPACITY = 16;

    localparam int REQ_W   = 2;
    localparam int KEY_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // shift up from the insert point, load key there
        logic del;   // shift down from the match point
    } sst_ctrl_t;

endpackage

@@ sv/sorted_set_table.sv @@
// ----------------------------------------------------------------------------
// sorted_set_table
// Sorted set of distinct signed 32-bit values with insert, delete and lookup.
// ----------------------------------------------------------------------------
// Usage: each item carries a request (insert, delete, look up) and a signed
// value; each item gives exactly one result with a status (done/found,
// duplicate/not found, full) and the entry count after the request. Values
// sit in a row of CAPACITY cells in ascending signed order; every cell
// compares its value with the key at once, so the insert or delete point is
// known at once and the cells shift up or down by one slot in the same
// cycle. An item executes while it sits in the request register, once the
// result register is empty or being taken; its result is offered from the
// result register in the cycle after that and waits there until taken. A
// result that is not taken holds the request register, and with it the
// input. While results are taken, the block sustains one item per cycle,
// limited by the single compare-and-shift pass through the cell row. No
// clearing pass is needed after reset: occupied flags clear at once.
// entry_count is the held count modulo 32 when CAPACITY exceeds 31.
// ----------------------------------------------------------------------------
module sorted_set_table
    import sst_pkg::*;
#(
    parameter int CAPACITY = SST_CAPACITY
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [REQ_W-1:0]     s_req_type,
    input  logic signed [KEY_W-1:0] s_key_value,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STAT_W-1:0]    m_status,
    output logic [COUNT_W-1:0]   m_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    // request register
    logic             req_valid_reg, req_valid_next;
    logic [REQ_W-1:0] req_type_reg;
    logic [KEY_W-1:0] req_key_reg;

    // result register
    logic               res_valid_reg, res_valid_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;

    logic [CW-1:0] count_reg, count_next;

    // cell row
    logic [KEY_W-1:0] entry [CAPACITY];
    logic [CAPACITY-1:0] occ, less, eq;
    sst_ctrl_t ctrl;

    logic advance;   // request executes this cycle
    logic found;
    logic full;
    logic [31:0] count_ext;

    assign advance = req_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || advance;

    assign found = |eq;
    assign full  = occ[CAPACITY-1];

    // ------------------------------------------------------------------
    // cell chain: slot 0 sees a virtual "less, occupied" neighbor below,
    // the top slot sees an empty neighbor above
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_W-1:0] l_entry, r_entry;
        logic             l_occ, l_less, r_occ;

        if (i == 0) begin : g_lo
            assign l_entry = req_key_reg;
            assign l_occ   = 1'b1;
            assign l_less  = 1'b1;
        end else begin : g_lo
            assign l_entry = entry[i-1];
            assign l_occ   = occ[i-1];
            assign l_less  = less[i-1];
        end

        if (i == CAPACITY - 1) begin : g_hi
            assign r_entry = req_key_reg;
            assign r_occ   = 1'b0;
        end else begin : g_hi
            assign r_entry = entry[i+1];
            assign r_occ   = occ[i+1];
        end

        sst_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .key         (req_key_reg),
            .left_entry  (l_entry),
            .left_occ    (l_occ),
            .left_less   (l_less),
            .right_entry (r_entry),
            .right_occ   (r_occ),
            .entry       (entry[i]),
            .occ         (occ[i]),
            .less        (less[i]),
            .eq          (eq[i])
        );
    end

    // ------------------------------------------------------------------
    // request decode: what the cells do and what the result says
    // ------------------------------------------------------------------
    always_comb begin
        ctrl            = '0;
        count_next      = count_reg;
        res_status_next = ST_MISS;
        if (advance) begin
            case (req_type_reg)
                REQ_INSERT: begin
                    if (found) begin
                        res_status_next = ST_MISS;    // duplicate wins over full
                    end else if (full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        ctrl.ins        = 1'b1;
                        count_next      = count_reg + CW'(1);
                        res_status_next = ST_OK;
                    end
                end
                REQ_DELETE: begin
                    if (found) begin
                        ctrl.del        = 1'b1;
                        count_next      = count_reg - CW'(1);
                        res_status_next = ST_OK;
                    end
                end
                REQ_LOOKUP: begin
                    res_status_next = found ? ST_OK : ST_MISS;
                end
                default: begin
                    res_status_next = ST_MISS;        // unused code: no change
                end
            endcase
        end
    end

    assign count_ext      = 32'(count_next);
    assign res_count_next = count_ext[COUNT_W-1:0];

    always_comb begin
        req_valid_next = req_valid_reg;
        if (s_valid && s_ready) begin
            req_valid_next = 1'b1;
        end else if (advance) begin
            req_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (advance) begin
            res_valid_next = 1'b1;
        end else if (m_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg <= s_req_type;
            req_key_reg  <= s_key_value;
        end
        if (advance) begin
            res_status_reg <= res_status_next;
            res_count_reg  <= res_count_next;
        end
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
            count_reg     <= count_next;
        end
    end

    assign m_valid       = res_valid_reg;
    assign m_status      = res_status_reg;
    assign m_entry_count = res_count_reg;

`ifndef SYNTHESIS
    // occupied flags always agree with the held count
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ) == 32'(count_reg))
        else $error("occupied cells disagree with count");

    // count never passes capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= CAPACITY)
        else $error("count above capacity");

    // a successful insert grows the table by one
    a_ins_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ins |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow count");

    // reset empties the result register
    a_rst_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

@@ sv/sst_cell.sv @@
// ----------------------------------------------------------------------------
// sst_cell
// One slot of the sorted chain: holds a value and its occupied flag,
// compares against the broadcast key and shifts to/from its neighbors.
// ----------------------------------------------------------------------------
module sst_cell
    import sst_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  sst_ctrl_t        ctrl,
    input  logic [KEY_W-1:0] key,
    // lower neighbor (slot i-1)
    input  logic [KEY_W-1:0] left_entry,
    input  logic             left_occ,
    input  logic             left_less,
    // upper neighbor (slot i+1)
    input  logic [KEY_W-1:0] right_entry,
    input  logic             right_occ,
    output logic [KEY_W-1:0] entry,
    output logic             occ,
    output logic             less,
    output logic             eq
);

    logic [KEY_W-1:0] entry_reg, entry_next;
    logic             occ_reg, occ_next;

    assign entry = entry_reg;
    assign occ   = occ_reg;
    assign less  = occ_reg && ($signed(entry_reg) < $signed(key));
    assign eq    = occ_reg && (entry_reg == key);

    always_comb begin
        entry_next = entry_reg;
        occ_next   = occ_reg;
        if (ctrl.ins && !less) begin
            entry_next = left_less ? key : left_entry;
            occ_next   = occ_reg | left_occ;
        end else if (ctrl.del && !less) begin
            entry_next = right_entry;
            occ_next   = right_occ;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

endmodule
